@@ design/gpr_pkg.sv @@
// shared types and constants of the gpio port register block
// no dependencies

package gpr_pkg;

    localparam int PIN_COUNT = 16;
    localparam logic [15:0] PIN_MASK = 16'((32'd1 << PIN_COUNT) - 32'd1);
    localparam logic [31:0] CFG_RESET = 32'h4444_4444;
    localparam int KEY_BIT = 16;

    typedef enum logic {
        FUNC_READ  = 1'b0,
        FUNC_WRITE = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        SEL_CFG_LOW  = 3'd0,
        SEL_CFG_HIGH = 3'd1,
        SEL_INPUT    = 3'd2,
        SEL_OUTPUT   = 3'd3,
        SEL_BSRR     = 3'd4,
        SEL_BRR      = 3'd5,
        SEL_LOCK     = 3'd6
    } t_reg_sel;

    typedef enum logic [1:0] {
        STEP_IDLE = 2'd0,
        STEP_ONE  = 2'd1,
        STEP_TWO  = 2'd2
    } t_lock_step;

    typedef struct packed {
        logic        wr;
        logic        rd;
        logic [15:0] bits;
        logic        key;
    } t_lock_req;

    typedef struct packed {
        logic [15:0] bits;
        logic        key;
        logic        key_shown;
    } t_lock_stat;

endpackage

@@ design/gpr_lock_ctrl.sv @@
// lock register and lock-key sequence of the gpio port
// depends on gpr_pkg

module gpr_lock_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gpr_pkg::t_lock_req i_req,
    output gpr_pkg::t_lock_stat o_stat
);
    import gpr_pkg::*;

    logic [15:0] r_bits, n_bits;
    logic        r_key, n_key;
    logic        r_shown, n_shown;
    t_lock_step  r_step, n_step;
    logic        same;
    t_lock_step  abort_step;

    assign same       = (i_req.bits & PIN_MASK) == r_bits;
    assign abort_step = i_req.key ? STEP_ONE : STEP_IDLE;

    always_comb begin
        n_bits  = r_bits;
        n_key   = r_key;
        n_shown = r_shown;
        n_step  = r_step;
        if (i_req.wr && !r_key) begin
            n_bits = i_req.bits & PIN_MASK;
            unique case (r_step)
                STEP_IDLE: begin
                    n_step = abort_step;
                end
                STEP_ONE: begin
                    if (!i_req.key && same) begin
                        n_step = STEP_TWO;
                    end else begin
                        n_step = abort_step;
                    end
                end
                STEP_TWO: begin
                    if (i_req.key && same) begin
                        n_step  = STEP_IDLE;
                        n_key   = 1'b1;
                        n_shown = 1'b0;
                    end else begin
                        n_step = abort_step;
                    end
                end
                default: begin
                    n_step = abort_step;
                end
            endcase
        end
        if (i_req.rd && r_key) begin
            n_shown = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= '0;
            r_key   <= 1'b0;
            r_shown <= 1'b0;
            r_step  <= STEP_IDLE;
        end else begin
            r_bits  <= n_bits;
            r_key   <= n_key;
            r_shown <= n_shown;
            r_step  <= n_step;
        end
    end

    assign o_stat.bits      = r_bits;
    assign o_stat.key       = r_key;
    assign o_stat.key_shown = r_shown;

endmodule

@@ design/gpio_port_register_block.sv @@
// top level of the gpio port register block
// depends on gpr_pkg and gpr_lock_ctrl

// One bus access per beat, and a new beat can be taken every clock cycle. A beat
// passes an input register and then the result register; the result register holds
// while the downstream side stalls, and the input side keeps taking beats as long as
// the result register can move on. Pins are sampled with each access, and config
// nibbles of locked pins stay frozen until reset once the lock-key sequence has
// completed.

module gpio_port_register_block (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // write_data[31:0], pin_levels[47:32]
    input  logic [3:0]  i_s_axis_tuser,  // func[0], reg_select[3:1]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata   // read_data[31:0], pin_drive[47:32],
                                         // lock_active[48], zero[55:49]
);
    import gpr_pkg::*;

    logic        r_in_valid;
    t_func       r_func;
    t_reg_sel    r_sel;
    logic [31:0] r_data;
    logic [15:0] r_pins;

    logic        r_out_valid;
    logic [31:0] r_rd, n_rd;

    logic [31:0] r_cfg_low, n_cfg_low;
    logic [31:0] r_cfg_high, n_cfg_high;
    logic [15:0] r_odr, n_odr;

    logic        advance;
    logic        in_take;
    logic [31:0] fz_low, fz_high;
    logic [15:0] idr;
    t_lock_req   lock_req;
    t_lock_stat  lock_stat;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func <= t_func'(i_s_axis_tuser[0]);
            r_sel  <= t_reg_sel'(i_s_axis_tuser[3:1]);
            r_data <= i_s_axis_tdata[31:0];
            r_pins <= i_s_axis_tdata[47:32];
        end
    end

    // nibble masks of locked pins
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            fz_low[4*i +: 4]  = {4{lock_stat.key & lock_stat.bits[i]}};
            fz_high[4*i +: 4] = {4{lock_stat.key & lock_stat.bits[i+8]}};
        end
    end

    assign idr = r_pins & PIN_MASK;

    always_comb begin
        n_cfg_low     = r_cfg_low;
        n_cfg_high    = r_cfg_high;
        n_odr         = r_odr;
        n_rd          = '0;
        lock_req.wr   = 1'b0;
        lock_req.rd   = 1'b0;
        lock_req.bits = r_data[15:0];
        lock_req.key  = r_data[KEY_BIT];
        if (r_func == FUNC_WRITE) begin
            case (r_sel)
                SEL_CFG_LOW:  n_cfg_low  = (r_cfg_low & fz_low) | (r_data & ~fz_low);
                SEL_CFG_HIGH: n_cfg_high = (r_cfg_high & fz_high) | (r_data & ~fz_high);
                SEL_OUTPUT:   n_odr = r_data[15:0] & PIN_MASK;
                SEL_BSRR:     n_odr = ((r_odr & ~r_data[31:16]) | r_data[15:0]) & PIN_MASK;
                SEL_BRR:      n_odr = r_odr & ~r_data[15:0] & PIN_MASK;
                SEL_LOCK:     lock_req.wr = 1'b1;
                default:      ;
            endcase
        end else begin
            case (r_sel)
                SEL_CFG_LOW:  n_rd = r_cfg_low;
                SEL_CFG_HIGH: n_rd = r_cfg_high;
                SEL_INPUT:    n_rd = {16'd0, idr};
                SEL_OUTPUT:   n_rd = {16'd0, r_odr};
                SEL_LOCK: begin
                    lock_req.rd = 1'b1;
                    n_rd = {15'd0, lock_stat.key & lock_stat.key_shown, lock_stat.bits};
                end
                default:      n_rd = '0;
            endcase
        end
        if (!(r_in_valid && advance)) begin
            lock_req.wr = 1'b0;
            lock_req.rd = 1'b0;
        end
    end

    gpr_lock_ctrl u_lock (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (lock_req),
        .o_stat  (lock_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_low   <= CFG_RESET;
            r_cfg_high  <= CFG_RESET;
            r_odr       <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_cfg_low  <= n_cfg_low;
                r_cfg_high <= n_cfg_high;
                r_odr      <= n_odr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_rd <= n_rd;
        end
    end

    // lock key and output latch are read from state, which already holds this beat
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, lock_stat.key, r_odr, r_rd};

endmodule

@@ verif/gpio_port_register_block_checker.sv @@
// result checker for the gpio port register block: tracks the port registers
// from accepted input beats and compares every output beat in order
// depends on gpr_pkg
`timescale 1ns / 1ps

module gpio_port_register_block_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,   // write_data[31:0], pin_levels[47:32]
    input  logic [3:0]  i_s_tuser,   // func[0], reg_select[3:1]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,   // read_data[31:0], pin_drive[47:32],
                                     // lock_active[48], zero[55:49]
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output logic        o_locked
);
    import gpr_pkg::*;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pin_drive;
        logic        lock_active;
    } t_port_result;

    logic [31:0]  cfg_low     = CFG_RESET;
    logic [31:0]  cfg_high    = CFG_RESET;
    logic [15:0]  pin_in      = '0;
    logic [15:0]  drive_latch = '0;
    logic [15:0]  lock_bits   = '0;
    logic         lock_key    = 1'b0;
    t_lock_step   lock_step   = STEP_IDLE;
    logic         key_shown   = 1'b0;

    t_port_result port_result_q[$];
    int           fail_count  = 0;
    int           checked     = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_locked     = 1'b0;
    end

    function automatic logic [31:0] frozen_nibbles(input logic key, input logic [7:0] locked);
        logic [31:0] mask;
        mask = '0;
        for (int i = 0; i < 8; i++) begin
            mask[4*i +: 4] = {4{locked[i]}};
        end
        return key ? mask : 32'd0;
    endfunction

    task automatic apply_bus_access(input t_func func, input logic [2:0] sel,
                                    input logic [31:0] wdata, input logic [15:0] pins,
                                    output t_port_result res);
        logic [31:0] frz;
        logic [31:0] rd;
        logic [15:0] bits;
        logic        key;
        logic        same;
        rd = '0;
        pin_in = pins & PIN_MASK;
        if (func == FUNC_WRITE) begin
            case (sel)
                SEL_CFG_LOW: begin
                    frz = frozen_nibbles(lock_key, lock_bits[7:0]);
                    cfg_low = (cfg_low & frz) | (wdata & ~frz);
                end
                SEL_CFG_HIGH: begin
                    frz = frozen_nibbles(lock_key, lock_bits[15:8]);
                    cfg_high = (cfg_high & frz) | (wdata & ~frz);
                end
                SEL_OUTPUT: drive_latch = wdata[15:0] & PIN_MASK;
                SEL_BSRR:   drive_latch = ((drive_latch & ~wdata[31:16]) | wdata[15:0])
                                          & PIN_MASK;
                SEL_BRR:    drive_latch = drive_latch & ~wdata[15:0] & PIN_MASK;
                SEL_LOCK: begin
                    bits = wdata[15:0] & PIN_MASK;
                    key  = wdata[KEY_BIT];
                    same = (bits == lock_bits);
                    if (!lock_key) begin
                        if (lock_step == STEP_IDLE) begin
                            lock_step = key ? STEP_ONE : STEP_IDLE;
                        end else if (lock_step == STEP_ONE && !key && same) begin
                            lock_step = STEP_TWO;
                        end else if (lock_step == STEP_TWO && key && same) begin
                            lock_step = STEP_IDLE;
                            lock_key  = 1'b1;
                            key_shown = 1'b0;
                        end else begin
                            lock_step = key ? STEP_ONE : STEP_IDLE;
                        end
                        lock_bits = bits;
                    end
                end
                default: ;
            endcase
        end else begin
            case (sel)
                SEL_CFG_LOW:  rd = cfg_low;
                SEL_CFG_HIGH: rd = cfg_high;
                SEL_INPUT:    rd = {16'd0, pin_in};
                SEL_OUTPUT:   rd = {16'd0, drive_latch};
                SEL_LOCK: begin
                    rd = {15'd0, lock_key & key_shown, lock_bits};
                    if (lock_key) key_shown = 1'b1;
                end
                default:      rd = '0;
            endcase
        end
        res = '{read_data: rd, pin_drive: drive_latch, lock_active: lock_key};
    endtask

    always @(posedge i_clk) begin : watch
        t_port_result want;
        t_port_result got;
        if (!i_rst_n) begin
            cfg_low     = CFG_RESET;
            cfg_high    = CFG_RESET;
            pin_in      = '0;
            drive_latch = '0;
            lock_bits   = '0;
            lock_key    = 1'b0;
            lock_step   = STEP_IDLE;
            key_shown   = 1'b0;
            port_result_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = '{read_data: i_m_tdata[31:0], pin_drive: i_m_tdata[47:32],
                        lock_active: i_m_tdata[48]};
                if (port_result_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat: rd=%h drive=%h lock=%b",
                                 got.read_data, got.pin_drive, got.lock_active);
                    fail_count++;
                end else begin
                    want = port_result_q.pop_front();
                    if (got != want || i_m_tdata[55:49] != '0) begin
                        if (fail_count < 10) begin
                            $write("mismatch on result %0d: expected rd=%h drive=%h lock=%b,",
                                   checked, want.read_data, want.pin_drive,
                                   want.lock_active);
                            $display(" got rd=%h drive=%h lock=%b pad=%h",
                                     got.read_data, got.pin_drive, got.lock_active,
                                     i_m_tdata[55:49]);
                        end
                        fail_count++;
                    end
                    checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_bus_access(t_func'(i_s_tuser[0]), i_s_tuser[3:1], i_s_tdata[31:0],
                                 i_s_tdata[47:32], want);
                port_result_q.push_back(want);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= port_result_q.size();
        o_checked    <= checked;
        o_locked     <= lock_key;
    end

endmodule

@@ verif/gpio_port_register_block_test.sv @@
// testbench top of the gpio port register block: drives bus access beats with
// random gaps and downstream stalls, and reports the checker's verdict
// depends on gpr_pkg, gpio_port_register_block and gpio_port_register_block_checker
`timescale 1ns / 1ps

module gpio_port_register_block_test;
    import gpr_pkg::*;

    localparam logic [2:0] SEL_UNUSED  = 3'd7;
    localparam int         STALL_LIMIT = 2000;
    localparam int         UNLOCKED_ITEMS = 620;
    localparam int         TOTAL_ITEMS    = 920;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [3:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    logic idle_on      = 1'b1;
    int   sent         = 0;
    int   quiet_cycles = 0;
    int   fail_count;
    int   pending;
    int   checked;
    logic locked;

    gpio_port_register_block i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    gpio_port_register_block_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_locked     (locked)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_tready <= !(idle_on && $urandom_range(0, 99) < 31);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("gpio_port_register_block_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_access(input t_func func, input logic [2:0] sel,
                               input logic [31:0] wdata, input logic [15:0] pins);
        while (idle_on && $urandom_range(0, 99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pins, wdata};
        s_tuser  <= {sel, func};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_random_access(input bit allow_lock);
        logic [2:0] sel;
        if ($urandom_range(0, 39) == 0)
            sel = SEL_UNUSED;
        else
            sel = 3'($urandom_range(0, allow_lock ? 6 : 5));
        send_access(t_func'($urandom_range(0, 1)), sel, random_word(), 16'(random_word()));
    endtask

    // key 1, key 0, key 1 with the same bits; a flaw breaks one step
    task automatic try_lock(input logic [15:0] bits, input bit complete);
        int          flaw;
        logic [15:0] flip;
        logic [15:0] bits2;
        logic [15:0] bits3;
        flaw  = complete ? 0 : $urandom_range(1, 4);
        flip  = 16'd1 << $urandom_range(0, 15);
        bits2 = (flaw == 2) ? bits ^ flip : bits;
        bits3 = (flaw == 4) ? bits2 ^ flip : bits2;
        send_access(FUNC_WRITE, SEL_LOCK, {15'($urandom), 1'b1, bits}, 16'($urandom));
        if ($urandom_range(0, 2) == 0) send_random_access(1'b0);
        send_access(FUNC_WRITE, SEL_LOCK, {15'($urandom), flaw == 1, bits2}, 16'($urandom));
        if ($urandom_range(0, 2) == 0) send_random_access(1'b0);
        send_access(FUNC_WRITE, SEL_LOCK, {15'($urandom), flaw != 3, bits3}, 16'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values of every register, pins high
        for (int s = 0; s < 8; s++) send_access(FUNC_READ, 3'(s), '0, 16'hFFFF);
        send_access(FUNC_WRITE, SEL_CFG_LOW,  32'hFFFF_FFFF, 16'h0000);
        send_access(FUNC_WRITE, SEL_CFG_HIGH, 32'h0000_0000, 16'h0000);
        send_access(FUNC_WRITE, SEL_INPUT,    32'hFFFF_FFFF, 16'h0000);
        send_access(FUNC_READ,  SEL_INPUT,    32'hFFFF_FFFF, 16'hA5A5);
        send_access(FUNC_WRITE, SEL_OUTPUT,   32'hFFFF_FFFF, 16'h5A5A);
        send_access(FUNC_WRITE, SEL_BSRR,     32'hFFFF_0000, 16'hFFFF);
        send_access(FUNC_WRITE, SEL_BSRR,     32'h0F0F_00FF, 16'hFFFF);
        send_access(FUNC_WRITE, SEL_BSRR,     32'hFFFF_FFFF, 16'h0000);
        send_access(FUNC_WRITE, SEL_BRR,      32'hFFFF_00F0, 16'h0000);
        send_access(FUNC_WRITE, SEL_UNUSED,   32'hFFFF_FFFF, 16'hFFFF);
        send_access(FUNC_READ,  SEL_BSRR,     32'hFFFF_FFFF, 16'hFFFF);
        send_access(FUNC_READ,  SEL_BRR,      32'hFFFF_FFFF, 16'hFFFF);
        send_access(FUNC_READ,  SEL_OUTPUT,   32'h0000_0000, 16'h0000);
        // aborted lock attempts
        send_access(FUNC_WRITE, SEL_LOCK,     32'hFFFF_FFFF, 16'h0000);
        send_access(FUNC_WRITE, SEL_LOCK,     32'h0000_0000, 16'h0000);
        send_access(FUNC_WRITE, SEL_LOCK,     32'h0000_FFFF, 16'h0000);
        send_access(FUNC_READ,  SEL_LOCK,     32'h0000_0000, 16'h0000);

        while (sent < UNLOCKED_ITEMS) begin
            idle_on = !(sent >= 220 && sent < 400);
            if ($urandom_range(0, 9) < 3)
                try_lock(16'(random_word()), 1'b0);
            else
                send_random_access(1'b1);
        end

        idle_on = 1'b1;
        try_lock(16'($urandom_range(1, 16'hFFFE)), 1'b1);
        send_access(FUNC_READ, SEL_LOCK, '0, 16'($urandom));
        send_access(FUNC_READ, SEL_LOCK, '0, 16'($urandom));

        while (sent < TOTAL_ITEMS) begin
            if ($urandom_range(0, 9) < 2)
                send_access(FUNC_WRITE, 3'($urandom_range(0, 1)), random_word(),
                            16'($urandom));
            else
                send_random_access(1'b1);
        end
        s_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);

        $display("covered %0d bus accesses with %0d results checked: all registers, set/reset,",
                 sent, checked);
        $display("aborted and completed lock sequences, config lock %s for the last phase",
                 locked ? "in force" : "not in force");
        if (fail_count == 0 && pending == 0)
            $display("gpio_port_register_block_test OK");
        else
            $display("gpio_port_register_block_test NOT OK");
        $finish;
    end

endmodule
